### hdl/sphdpe_pkg.sv
package sphdpe_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int COUNT_W = 7;
	localparam int POS_W = 32;
	localparam int QV_W = 31;
	localparam int K_W = 32;
	localparam int PIDX_W = 6;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_W-1:0] COUNT_RST = 7'd64;
	localparam logic [QV_W-1:0] RADIUS_RST = 31'd1048576;
	localparam logic [QV_W-1:0] TARGET_RST = 31'd65536;
	localparam logic [QV_W-1:0] COEF_RST = 31'd65536;
	localparam logic [QV_W-1:0] MASS_RST = 31'd65536;
	localparam logic [K_W-1:0] NORM_RST = 32'd125153;
	localparam logic [K_W-1:0] SLOPE_RST = 32'd250306;

	typedef enum logic [CFG_AW-1:0] {
		REG_COUNT  = 3'd0,
		REG_RADIUS = 3'd1,
		REG_TARGET = 3'd2,
		REG_COEF   = 3'd3,
		REG_MASS   = 3'd4,
		REG_NORM   = 3'd5,
		REG_SLOPE  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [QV_W-1:0]    radius;
		logic [QV_W-1:0]    target;
		logic [QV_W-1:0]    coef;
		logic [QV_W-1:0]    mass;
		logic [K_W-1:0]     norm;
		logic [K_W-1:0]     slope;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             last;
	} load_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### hdl/sphdpe_front.sv
module sphdpe_front import sphdpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2*POS_W-1:0] in_data,
	input  logic [COUNT_W-1:0] n_eff,
	input  q_stat_t            q_stat,
	output logic               q_push,
	output load_t              q_entry
);

	logic [COUNT_W-1:0] load_cnt_q;
	logic [COUNT_W-1:0] cnt_nxt;
	logic               is_last;

	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && in_ready;
	assign cnt_nxt  = load_cnt_q + COUNT_W'(1);
	// a lowered count mid-run still closes the run here
	assign is_last  = (cnt_nxt >= n_eff);

	assign q_entry.x    = in_data[POS_W-1:0];
	assign q_entry.y    = in_data[2*POS_W-1:POS_W];
	assign q_entry.last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (q_push) begin
			load_cnt_q <= is_last ? '0 : cnt_nxt;
		end
	end

endmodule

### hdl/sphdpe_queue.sv
module sphdpe_queue import sphdpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  load_t   push_data,
	input  logic    pop,
	output load_t   pop_data,
	output q_stat_t stat
);

	load_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/sphdpe_isqrt.sv
module sphdpe_isqrt import sphdpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [62:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [62:0] v_q;
	logic [62:0] r_q;
	logic [62:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [62:0] trial;

	assign trial = r_q + bit_q;
	assign done  = done_q;
	assign root  = r_q[31:0];

	// two radicand bits per step, 32 steps
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= 63'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

### hdl/sphdpe_div.sv
module sphdpe_div import sphdpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);

	// caller keeps num[63:32] below den, so the quotient fits 32 bits
	logic [31:0] rem_q;
	logic [31:0] nlo_q;
	logic [31:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] r2;
	logic [32:0] diff;
	logic        ge;

	assign r2   = {rem_q, nlo_q[31]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});
	assign done = done_q;
	assign quot = nlo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[63:32];
			nlo_q <= num[31:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : r2[31:0];
			nlo_q <= {nlo_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

### hdl/sphdpe_back.sv
module sphdpe_back import sphdpe_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic [COUNT_W-1:0] n_eff,
	input  q_stat_t            q_stat,
	input  load_t              q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIDX_W-1:0]  out_idx,
	output logic [QV_W-1:0]    out_density,
	output logic [31:0]        out_fx,
	output logic [31:0]        out_fy,
	output logic               out_last
);

	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

	typedef enum logic [35:0] {
		ST_IDLE  = 36'd1 << 0,
		ST_LDI   = 36'd1 << 1,
		ST_GETI  = 36'd1 << 2,
		ST_PI    = 36'd1 << 3,
		ST_PIW   = 36'd1 << 4,
		ST_LDJ   = 36'd1 << 5,
		ST_GETJ  = 36'd1 << 6,
		ST_SQX   = 36'd1 << 7,
		ST_SQY   = 36'd1 << 8,
		ST_SQS   = 36'd1 << 9,
		ST_SQW   = 36'd1 << 10,
		ST_RANGE = 36'd1 << 11,
		ST_W     = 36'd1 << 12,
		ST_INF   = 36'd1 << 13,
		ST_ACC   = 36'd1 << 14,
		ST_PJ    = 36'd1 << 15,
		ST_SH    = 36'd1 << 16,
		ST_G     = 36'd1 << 17,
		ST_M1    = 36'd1 << 18,
		ST_M2    = 36'd1 << 19,
		ST_M3    = 36'd1 << 20,
		ST_M4    = 36'd1 << 21,
		ST_M5    = 36'd1 << 22,
		ST_QD    = 36'd1 << 23,
		ST_QW    = 36'd1 << 24,
		ST_CX    = 36'd1 << 25,
		ST_CXD   = 36'd1 << 26,
		ST_CXW   = 36'd1 << 27,
		ST_CY    = 36'd1 << 28,
		ST_CYD   = 36'd1 << 29,
		ST_CYW   = 36'd1 << 30,
		ST_NEXTJ = 36'd1 << 31,
		ST_RHO1  = 36'd1 << 32,
		ST_RHO2  = 36'd1 << 33,
		ST_RHO3  = 36'd1 << 34,
		ST_EMIT  = 36'd1 << 35
	} st_t;

	st_t                state_q, state_d;
	logic               force_q;
	logic [IDX_W-1:0]   i_q, j_q, wr_idx_q, rd_addr;
	logic [COUNT_W-1:0] n_q;
	logic               i_last, j_last;

	logic [31:0] x_mem [MAX_PARTICLES];
	logic [31:0] y_mem [MAX_PARTICLES];
	logic [30:0] d_mem [MAX_PARTICLES];
	logic [31:0] rd_x_q, rd_y_q;
	logic [30:0] rd_d_q;
	logic        pos_we, den_we;

	logic [31:0] xi_q, yi_q;
	logic [30:0] rhoi_q, rhoj_q;
	logic [45:0] pi_q, shared_q;
	logic [30:0] ax_q, ay_q, t_q, g_q;
	logic        nx_q, ny_q, big_q;
	logic [61:0] ssq_q;
	logic [31:0] d_q, q_q;
	logic [51:0] acc_q;
	logic [63:0] lo_q, prod_q;
	logic [60:0] m_q;
	logic [46:0] m2_q;
	logic [39:0] fx_q, fy_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_c;
	logic [32:0] dx_c, dy_c, adx_c, ady_c;
	logic        far_c, q_cap_c;
	logic [91:0] sum92_c;
	logic [82:0] sum83_c;
	logic [30:0] rho_raw_c, rho_fin_c;

	logic        sq_start, sq_done;
	logic [31:0] sq_root;
	logic        dv_start, dv_done;
	logic [63:0] dv_num;
	logic [31:0] dv_den, dv_quot;
	logic        out_load;

	logic              out_valid_q, out_last_q;
	logic [PIDX_W-1:0] out_idx_q;
	logic [QV_W-1:0]   out_den_q;
	logic [31:0]       out_fx_q, out_fy_q;

	function automatic logic [31:0] sat32(input logic [39:0] v);
		if (v[39:31] == '0 || v[39:31] == '1) begin
			return v[31:0];
		end else if (v[39]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7FFF_FFFF;
		end
	endfunction

	sphdpe_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (63'(ssq_q) + 63'(prod_q[61:0])),
		.done     (sq_done),
		.root     (sq_root)
	);

	sphdpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	assign i_last  = (COUNT_W'(i_q) == n_q - COUNT_W'(1));
	assign j_last  = (COUNT_W'(j_q) == n_q - COUNT_W'(1));
	assign rd_addr = (state_q == ST_LDI) ? i_q : j_q;
	assign prod_c  = mul_a * mul_b;

	assign dx_c  = {rd_x_q[31], rd_x_q} - {xi_q[31], xi_q};
	assign dy_c  = {rd_y_q[31], rd_y_q} - {yi_q[31], yi_q};
	assign adx_c = dx_c[32] ? (33'd0 - dx_c) : dx_c;
	assign ady_c = dy_c[32] ? (33'd0 - dy_c) : dy_c;
	assign far_c = adx_c[32] || adx_c[31] || ady_c[32] || ady_c[31];

	assign sum92_c = {prod_q[59:0], 32'd0} + 92'(lo_q);
	assign q_cap_c = big_q || (m2_q[46:16] >= rhoj_q);
	assign sum83_c = {prod_q[50:0], 32'd0} + 83'(lo_q);
	assign rho_raw_c = (sum83_c[82:47] != '0) ? '1 : sum83_c[46:16];
	assign rho_fin_c = (rho_raw_c < cfg.target) ? cfg.target : rho_raw_c;

	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		q_pop    = 1'b0;
		pos_we   = 1'b0;
		den_we   = 1'b0;
		sq_start = 1'b0;
		dv_start = 1'b0;
		dv_num   = prod_q;
		dv_den   = d_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					q_pop  = 1'b1;
					pos_we = 1'b1;
					if (q_data.last) begin
						state_d = ST_LDI;
					end
				end
			end
			ST_LDI:  state_d = ST_GETI;
			ST_GETI: state_d = force_q ? ST_PI : ST_LDJ;
			ST_PI: begin
				mul_a   = {1'b0, rhoi_q - cfg.target};
				mul_b   = {1'b0, cfg.coef};
				state_d = ST_PIW;
			end
			ST_PIW:  state_d = ST_GETJ;
			ST_LDJ:  state_d = ST_GETJ;
			ST_GETJ: state_d = far_c ? ST_NEXTJ : ST_SQX;
			ST_SQX: begin
				mul_a   = {1'b0, ax_q};
				mul_b   = {1'b0, ax_q};
				state_d = ST_SQY;
			end
			ST_SQY: begin
				mul_a   = {1'b0, ay_q};
				mul_b   = {1'b0, ay_q};
				state_d = ST_SQS;
			end
			ST_SQS: begin
				sq_start = 1'b1;
				state_d  = ST_SQW;
			end
			ST_SQW: if (sq_done) state_d = ST_RANGE;
			ST_RANGE: begin
				if (d_q >= {1'b0, cfg.radius}) begin
					state_d = ST_NEXTJ;
				end else if (!force_q) begin
					state_d = ST_W;
				end else if (d_q == '0 || rhoj_q == '0) begin
					state_d = ST_NEXTJ;
				end else begin
					state_d = ST_PJ;
				end
			end
			ST_W: begin
				mul_a   = {1'b0, t_q};
				mul_b   = cfg.norm;
				state_d = ST_INF;
			end
			ST_INF: begin
				mul_a   = {1'b0, prod_q[62:32]};
				mul_b   = {1'b0, t_q};
				state_d = ST_ACC;
			end
			ST_ACC: state_d = ST_NEXTJ;
			ST_PJ: begin
				mul_a   = {1'b0, rhoj_q - cfg.target};
				mul_b   = {1'b0, cfg.coef};
				state_d = ST_SH;
			end
			ST_SH: begin
				mul_a   = {1'b0, t_q};
				mul_b   = cfg.slope;
				state_d = ST_G;
			end
			ST_G: begin
				mul_a   = shared_q[31:0];
				mul_b   = {1'b0, prod_q[62:32]};
				state_d = ST_M1;
			end
			ST_M1: begin
				mul_a   = {18'd0, shared_q[45:32]};
				mul_b   = {1'b0, g_q};
				state_d = ST_M2;
			end
			ST_M2: state_d = ST_M3;
			ST_M3: begin
				mul_a   = m_q[31:0];
				mul_b   = {1'b0, cfg.mass};
				state_d = ST_M4;
			end
			ST_M4: begin
				mul_a   = {3'd0, m_q[60:32]};
				mul_b   = {1'b0, cfg.mass};
				state_d = ST_M5;
			end
			ST_M5: state_d = ST_QD;
			ST_QD: begin
				if (q_cap_c) begin
					state_d = ST_CX;
				end else begin
					dv_start = 1'b1;
					dv_num   = {1'b0, m2_q, 16'd0};
					dv_den   = {1'b0, rhoj_q};
					state_d  = ST_QW;
				end
			end
			ST_QW: if (dv_done) state_d = ST_CX;
			ST_CX: begin
				mul_a   = q_q;
				mul_b   = {1'b0, ax_q};
				state_d = ST_CXD;
			end
			ST_CXD: begin
				dv_start = 1'b1;
				state_d  = ST_CXW;
			end
			ST_CXW: if (dv_done) state_d = ST_CY;
			ST_CY: begin
				mul_a   = q_q;
				mul_b   = {1'b0, ay_q};
				state_d = ST_CYD;
			end
			ST_CYD: begin
				dv_start = 1'b1;
				state_d  = ST_CYW;
			end
			ST_CYW: if (dv_done) state_d = ST_NEXTJ;
			ST_NEXTJ: begin
				if (j_last) begin
					state_d = force_q ? ST_EMIT : ST_RHO1;
				end else begin
					state_d = ST_LDJ;
				end
			end
			ST_RHO1: begin
				mul_a   = acc_q[31:0];
				mul_b   = {1'b0, cfg.mass};
				state_d = ST_RHO2;
			end
			ST_RHO2: begin
				mul_a   = {12'd0, acc_q[51:32]};
				mul_b   = {1'b0, cfg.mass};
				state_d = ST_RHO3;
			end
			ST_RHO3: begin
				den_we  = 1'b1;
				state_d = ST_LDI;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = i_last ? ST_IDLE : ST_LDI;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			x_mem[wr_idx_q] <= q_data.x;
			y_mem[wr_idx_q] <= q_data.y;
		end
		if (den_we) begin
			d_mem[i_q] <= rho_fin_c;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
		rd_d_q <= d_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			force_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= COUNT_W'(2);
			wr_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_data.last) begin
							wr_idx_q <= '0;
							n_q      <= n_eff;
							i_q      <= '0;
							force_q  <= 1'b0;
						end else begin
							wr_idx_q <= wr_idx_q + IDX_W'(1);
						end
					end
				end
				ST_GETI: j_q <= '0;
				ST_NEXTJ: if (!j_last) j_q <= j_q + IDX_W'(1);
				ST_RHO3: begin
					if (i_last) begin
						i_q     <= '0;
						force_q <= 1'b1;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				ST_EMIT: if (out_load && !i_last) i_q <= i_q + IDX_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		case (state_q)
			ST_GETI: begin
				xi_q   <= rd_x_q;
				yi_q   <= rd_y_q;
				rhoi_q <= rd_d_q;
				acc_q  <= '0;
				fx_q   <= '0;
				fy_q   <= '0;
			end
			ST_PIW: pi_q <= prod_q[61:16];
			ST_GETJ: begin
				ax_q   <= adx_c[30:0];
				ay_q   <= ady_c[30:0];
				nx_q   <= dx_c[32];
				ny_q   <= dy_c[32];
				rhoj_q <= rd_d_q;
			end
			ST_SQY: ssq_q <= prod_q[61:0];
			ST_SQW: if (sq_done) d_q <= sq_root;
			ST_RANGE: t_q <= cfg.radius - d_q[30:0];
			ST_ACC: acc_q <= acc_q + 52'(prod_q[61:16]);
			ST_SH: shared_q <= 46'((47'(pi_q) + 47'(prod_q[61:16])) >> 1);
			ST_G: g_q <= prod_q[62:32];
			ST_M1: lo_q <= prod_q;
			ST_M2: m_q <= {prod_q[44:0], 16'd0} + 61'(lo_q[63:16]);
			ST_M4: lo_q <= prod_q;
			ST_M5: begin
				big_q <= (sum92_c[91:63] != '0);
				m2_q  <= sum92_c[62:16];
			end
			ST_QD: if (q_cap_c) q_q <= '1;
			ST_QW: if (dv_done) q_q <= dv_quot;
			ST_CXW: begin
				if (dv_done) begin
					fx_q <= nx_q ? fx_q + 40'(dv_quot) : fx_q - 40'(dv_quot);
				end
			end
			ST_CYW: begin
				if (dv_done) begin
					fy_q <= ny_q ? fy_q + 40'(dv_quot) : fy_q - 40'(dv_quot);
				end
			end
			ST_RHO2: lo_q <= prod_q;
			ST_EMIT: begin
				if (out_load) begin
					out_idx_q  <= PIDX_W'(i_q);
					out_den_q  <= rhoi_q;
					out_fx_q   <= sat32(fx_q);
					out_fy_q   <= sat32(fy_q);
					out_last_q <= i_last;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_idx     = out_idx_q;
	assign out_density = out_den_q;
	assign out_fx      = out_fx_q;
	assign out_fy      = out_fy_q;
	assign out_last    = out_last_q;

endmodule

### hdl/sph_density_pressure_engine_core.sv
// Channel   Direction  tdata (low bit up)                                  tuser/tlast
// s_axis    in         pos_x[31:0], pos_y[63:32]                             -
// m_axis    out        index[5:0], density[36:6], force_x[68:37],            tlast = last_result
//                      force_y[100:69], zero[103:101]
// cfg       in         cfg_we, cfg_addr (register index), cfg_wdata          -
//
// Loads queue ahead of the sequencer; each pair that passes the coarse distance check
// takes a 32-step square root and each force term up to three 32-step divisions,
// all on one shared multiplier, one root unit and one divider.
// Reset clears control and counters only; position and density memories are
// written before they are read, so they get no clearing pass.
// Loads keep flowing into the queue while results stall, until the queue is full; a
// result waits in the output register without holding up the sequencer's next particle.
module sph_density_pressure_engine_core import sphdpe_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [63:0]        s_axis_tdata,   // pos_x, pos_y
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [103:0]       m_axis_tdata,   // index, density, force_x, force_y, pad
	output logic               m_axis_tlast,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [CFG_DW-1:0]  cfg_wdata
);

	localparam logic [COUNT_W-1:0] N_MAX = COUNT_W'(MAX_PARTICLES);

	cfg_t               cfg_q;
	logic [COUNT_W-1:0] n_eff;
	q_stat_t            q_stat;
	load_t              q_entry, q_head;
	logic               q_push, q_pop;
	logic [PIDX_W-1:0]  res_idx;
	logic [QV_W-1:0]    res_den;
	logic [31:0]        res_fx, res_fy;

	// clamp the batch size into the supported range
	always_comb begin
		if (cfg_q.count < COUNT_W'(2)) begin
			n_eff = COUNT_W'(2);
		end else if (cfg_q.count > N_MAX) begin
			n_eff = N_MAX;
		end else begin
			n_eff = cfg_q.count;
		end
	end

	// register file: writes to unused indices drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count  <= COUNT_RST;
			cfg_q.radius <= RADIUS_RST;
			cfg_q.target <= TARGET_RST;
			cfg_q.coef   <= COEF_RST;
			cfg_q.mass   <= MASS_RST;
			cfg_q.norm   <= NORM_RST;
			cfg_q.slope  <= SLOPE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_COUNT:  cfg_q.count  <= cfg_wdata[COUNT_W-1:0];
				REG_RADIUS: cfg_q.radius <= cfg_wdata[QV_W-1:0];
				REG_TARGET: cfg_q.target <= cfg_wdata[QV_W-1:0];
				REG_COEF:   cfg_q.coef   <= cfg_wdata[QV_W-1:0];
				REG_MASS:   cfg_q.mass   <= cfg_wdata[QV_W-1:0];
				REG_NORM:   cfg_q.norm   <= cfg_wdata[K_W-1:0];
				REG_SLOPE:  cfg_q.slope  <= cfg_wdata[K_W-1:0];
				default:    ;
			endcase
		end
	end

	// front: take loads, mark the one that closes the run
	sphdpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.n_eff    (n_eff),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	sphdpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.pop       (q_pop),
		.pop_data  (q_head),
		.stat      (q_stat)
	);

	// back: store positions, run the density and force passes
	sphdpe_back #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.n_eff       (n_eff),
		.q_stat      (q_stat),
		.q_data      (q_head),
		.q_pop       (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_idx     (res_idx),
		.out_density (res_den),
		.out_fx      (res_fx),
		.out_fy      (res_fy),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, res_fy, res_fx, res_den, res_idx};

endmodule

### hdl/sphdpe_checker.sv
module sphdpe_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	// a stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[103:101] == 3'd0)
		else $error("padding bits set");

	// a run always has at least two particles
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] != 6'd0)
		else $error("last result on particle zero");

	a_rst: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid in reset");

endmodule

bind sph_density_pressure_engine_core sphdpe_checker u_sphdpe_checker (.*);

### sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sphdpe_pkg::*;

	localparam int  N_RANDOM_LOADS = 420;
	localparam longint CYCLE_LIMIT = 12_000_000;
	localparam logic [31:0] QMAX31 = 32'h7fff_ffff;

	// One result transaction as the block reports it
	typedef struct {
		logic [5:0]  idx;
		logic [30:0] dens;
		logic [31:0] fx;
		logic [31:0] fy;
		logic        last;
	} particle_res_t;

	// Directed stimulus: group selects the register setting applied before the row
	typedef struct {
		int          grp;
		logic [31:0] x;
		logic [31:0] y;
		bit          fixed;  // batch result is typed in: density = target, no force
	} load_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata = '0;   // pos_x[31:0], pos_y[63:32]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;        // index[5:0], density[36:6], fx[68:37], fy[100:69]
	logic         m_axis_tlast;
	logic         cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	// Predictor copy of the registers and stores
	logic [6:0]  p_count  = COUNT_RST;
	logic [30:0] p_radius = RADIUS_RST;
	logic [30:0] p_target = TARGET_RST;
	logic [30:0] p_coef   = COEF_RST;
	logic [30:0] p_mass   = MASS_RST;
	logic [31:0] p_norm   = NORM_RST;
	logic [31:0] p_slope  = SLOPE_RST;
	logic [31:0] pos_x_mem [64];
	logic [31:0] pos_y_mem [64];
	logic [31:0] dens_mem  [64];
	int          loads_held = 0;

	particle_res_t pending_results[$];
	int     errors = 0;
	int     loads_sent = 0;
	longint cycles = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	bit     typed_batch = 1'b0;

	sph_density_pressure_engine_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// Watchdog: abandon the run if the block stops making progress
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver back-pressure, redrawn every cycle at the falling edge
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Product of two magnitudes, shifted down and capped
	function automatic longint unsigned mul_cap(longint unsigned a, longint unsigned b,
			int sh, longint unsigned cap);
		logic [127:0] p;
		begin
			p = ({64'd0, a} * {64'd0, b}) >> sh;
			return (p > {64'd0, cap}) ? cap : p[63:0];
		end
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		begin
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		end
	endfunction

	// Separation of particle j from particle i; returns 1 when within the radius
	function automatic bit neighbour_near(int i, int j, output longint unsigned ax,
			output bit nx, output longint unsigned ay, output bit ny,
			output longint unsigned sep);
		longint dx, dy;
		begin
			dx = longint'($signed(pos_x_mem[j])) - longint'($signed(pos_x_mem[i]));
			dy = longint'($signed(pos_y_mem[j])) - longint'($signed(pos_y_mem[i]));
			nx = dx < 0;
			ny = dy < 0;
			ax = nx ? -dx : dx;
			ay = ny ? -dy : dy;
			sep = 0;
			if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
				return 1'b0;
			sep = int_root(ax * ax + ay * ay);
			return sep < p_radius;
		end
	endfunction

	function automatic logic [31:0] clamp_s32(longint v);
		begin
			if (v > 64'sd2147483647)
				return 32'h7fff_ffff;
			if (v < -64'sd2147483648)
				return 32'h8000_0000;
			return v[31:0];
		end
	endfunction

	// Store one accepted position; on the batch-closing load queue the per-particle results
	task automatic absorb_load(logic [31:0] x, logic [31:0] y);
		int n;
		longint unsigned ax, ay, sep, acc, rho, t, pi, pj, rj, shared, g, m, m2, q, cx, cy;
		bit nx, ny;
		longint fx, fy;
		particle_res_t r;
		begin
			n = p_count;
			if (n < 2)
				n = 2;
			if (n > 64)
				n = 64;
			pos_x_mem[loads_held & 63] = x;
			pos_y_mem[loads_held & 63] = y;
			loads_held++;
			if (loads_held < n)
				return;
			loads_held = 0;

			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					if (neighbour_near(i, j, ax, nx, ay, ny, sep)) begin
						t = p_radius - sep;
						acc += (((t * p_norm) >> 32) * t) >> 16;
					end
				rho = mul_cap(acc, p_mass, 16, QMAX31);
				if (rho < p_target)
					rho = p_target;
				dens_mem[i] = rho[31:0];
			end

			for (int i = 0; i < n; i++) begin
				fx = 0;
				fy = 0;
				pi = (longint'(p_coef) * (dens_mem[i] - p_target)) >> 16;
				for (int j = 0; j < n; j++) begin
					rj = dens_mem[j];
					if (!neighbour_near(i, j, ax, nx, ay, ny, sep) || sep == 0 || rj == 0)
						continue;
					pj = (longint'(p_coef) * (rj - p_target)) >> 16;
					shared = (pi + pj) >> 1;
					t = p_radius - sep;
					g = (t * p_slope) >> 32;
					m = mul_cap(shared, g, 16, 64'd1 << 62);
					m2 = mul_cap(m, p_mass, 16, 64'd1 << 62);
					if (m2 >= (64'd1 << 47)) begin
						q = 64'hffff_ffff;
					end else begin
						q = (m2 << 16) / rj;
						if (q > 64'hffff_ffff)
							q = 64'hffff_ffff;
					end
					cx = q * ax / sep;
					cy = q * ay / sep;
					fx += nx ? longint'(cx) : -longint'(cx);
					fy += ny ? longint'(cy) : -longint'(cy);
				end
				r.idx  = i[5:0];
				r.last = (i == n - 1);
				if (typed_batch) begin
					r.dens = p_target;
					r.fx   = '0;
					r.fy   = '0;
				end else begin
					r.dens = dens_mem[i][30:0];
					r.fx   = clamp_s32(fx);
					r.fy   = clamp_s32(fy);
				end
				pending_results.push_back(r);
			end
		end
	endtask

	// Result checker: compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		particle_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.idx  = m_axis_tdata[5:0];
			got.dens = m_axis_tdata[36:6];
			got.fx   = m_axis_tdata[68:37];
			got.fy   = m_axis_tdata[100:69];
			got.last = m_axis_tlast;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: idx %0d dens %h fx %h fy %h last %b",
					$time, got.idx, got.dens, got.fx, got.fy, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got.idx !== want.idx || got.dens !== want.dens || got.fx !== want.fx
						|| got.fy !== want.fy || got.last !== want.last) begin
					errors++;
					$display("%0t mismatch: expected idx %0d dens %h fx %h fy %h last %b",
						$time, want.idx, want.dens, want.fx, want.fy, want.last);
					$display("%0t            actual idx %0d dens %h fx %h fy %h last %b",
						$time, got.idx, got.dens, got.fx, got.fy, got.last);
				end
			end
		end
	end

	// Offer one position; hold it until the handshake completes, then predict
	task automatic send_position(logic [31:0] x, logic [31:0] y);
		begin
			@(negedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {y, x};
			do @(posedge clk); while (!s_axis_tready);
			absorb_load(x, y);
			loads_sent++;
		end
	endtask

	// Drop valid, let outstanding results drain and the load queue settle
	task automatic drain_block();
		begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
			repeat (60) @(posedge clk);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_addr  <= idx;
			cfg_wdata <= v;
			@(negedge clk);
			cfg_we <= 1'b0;
			case (idx)
				REG_COUNT:  p_count  = v[6:0];
				REG_RADIUS: p_radius = v[30:0];
				REG_TARGET: p_target = v[30:0];
				REG_COEF:   p_coef   = v[30:0];
				REG_MASS:   p_mass   = v[30:0];
				REG_NORM:   p_norm   = v;
				REG_SLOPE:  p_slope  = v;
				default: ;
			endcase
		end
	endtask

	// Register settings for each directed group
	task automatic apply_group(int grp);
		begin
			drain_block();
			case (grp)
				0: begin  // zero radius: nothing in range, densities sit at target
					write_reg(REG_COUNT, 32'd2);
					write_reg(REG_RADIUS, 32'd0);
					write_reg(REG_TARGET, 32'h7fff_ffff);
				end
				1: begin  // count below range, coincident particles
					write_reg(REG_COUNT, 32'd0);
					write_reg(REG_RADIUS, 32'h0010_0000);
					write_reg(REG_TARGET, 32'h0001_0000);
				end
				2: begin  // zero mass and target: every neighbour density is zero
					write_reg(REG_COUNT, 32'd1);
					write_reg(REG_MASS, 32'd0);
					write_reg(REG_TARGET, 32'd0);
				end
				3: begin
					write_reg(REG_COUNT, 32'd5);
					write_reg(REG_MASS, 32'h0001_0000);
					write_reg(REG_COEF, 32'h0004_0000);
				end
				4: write_reg(REG_COUNT, 32'd2);  // lower the count part-way through a batch
				5: begin  // radius, coef, mass, norm and slope at their top: saturate densities and forces
					write_reg(REG_COUNT, 32'd3);
					write_reg(REG_RADIUS, 32'h7fff_ffff);
					write_reg(REG_COEF, 32'h7fff_ffff);
					write_reg(REG_MASS, 32'h7fff_ffff);
					write_reg(REG_NORM, 32'hffff_ffff);
					write_reg(REG_SLOPE, 32'hffff_ffff);
				end
				6: begin  // separation of 2^31 or more counts as out of range
					write_reg(REG_COUNT, 32'd2);
					write_reg(REG_NORM, NORM_RST);
					write_reg(REG_SLOPE, SLOPE_RST);
				end
				default: ;
			endcase
		end
	endtask

	load_row_t directed_rows[] = '{
		'{0, 32'h7fff_ffff, 32'h8000_0000, 1'b1},
		'{0, 32'h8000_0000, 32'h7fff_ffff, 1'b1},
		'{1, 32'h0000_0000, 32'h0000_0000, 1'b0},
		'{1, 32'h0000_0000, 32'h0000_0000, 1'b0},
		'{2, 32'h0000_8000, 32'hffff_0000, 1'b0},
		'{2, 32'h0001_0000, 32'hffff_8000, 1'b0},
		'{3, 32'h0000_0000, 32'h0000_0000, 1'b0},
		'{3, 32'h0000_4000, 32'h0000_2000, 1'b0},
		'{3, 32'hffff_c000, 32'h0000_6000, 1'b0},
		'{4, 32'h1234_0000, 32'h5678_0000, 1'b0},
		'{5, 32'h0000_0000, 32'h0000_0000, 1'b0},
		'{5, 32'h0000_0001, 32'h0000_0000, 1'b0},
		'{5, 32'h0000_0000, 32'hffff_ffff, 1'b0},
		'{6, 32'h7fff_ffff, 32'h0000_0000, 1'b0},
		'{6, 32'h8000_0000, 32'h0000_0000, 1'b0}
	};

	// Random register setting for one phase; small counts keep the n-squared cost down
	task automatic shuffle_registers(bit big_batch, output int batch_len,
			output logic [31:0] spread);
		logic [31:0] cnt;
		begin
			drain_block();
			typed_batch = 1'b0;
			if (big_batch)
				cnt = 32'h7f;                // above the maximum: acts as 64
			else
				cnt = {$urandom_range(0, 1) ? 25'd0 : 25'($urandom()),
					7'($urandom_range(0, 5))};
			write_reg(REG_COUNT, cnt);
			batch_len = (cnt[6:0] < 2) ? 2 : (cnt[6:0] > 64) ? 64 : cnt[6:0];
			case ($urandom_range(0, 3))
				0: spread = $urandom_range(1, 32'h0000_ffff);
				1: spread = $urandom_range(32'h0001_0000, 32'h0040_0000);
				2: spread = $urandom_range(32'h0040_0000, 32'h0200_0000);
				default: spread = $urandom_range(1, 32'h0010_0000);
			endcase
			write_reg(REG_RADIUS, {1'($urandom_range(0, 1)), spread[30:0]});
			write_reg(REG_TARGET, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000));
			write_reg(REG_COEF, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0010_0000));
			write_reg(REG_MASS, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0004_0000));
			write_reg(REG_NORM, $urandom());
			write_reg(REG_SLOPE, $urandom());
		end
	endtask

	initial begin
		int cur_grp, batch_len, phase;
		logic [31:0] spread, cx, cy;
		bit noisy;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part
		cur_grp = -1;
		foreach (directed_rows[k]) begin
			if (directed_rows[k].grp != cur_grp) begin
				cur_grp = directed_rows[k].grp;
				apply_group(cur_grp);
			end
			typed_batch = directed_rows[k].fixed;
			send_position(directed_rows[k].x, directed_rows[k].y);
		end

		// Random part: idling profile cycles through the phases
		phase = 0;
		while (loads_sent < N_RANDOM_LOADS + directed_rows.size()) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			shuffle_registers(phase == 9, batch_len, spread);
			// a few whole batches per setting; most clustered, some full-range noise
			repeat ($urandom_range(1, 4)) begin
				noisy = ($urandom_range(0, 5) == 0);
				cx = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
				cy = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
				for (int k = 0; k < batch_len; k++) begin
					if (noisy)
						send_position($urandom(), $urandom());
					else
						send_position(cx + $urandom_range(0, 2 * spread) - spread,
							cy + $urandom_range(0, 2 * spread) - spread);
				end
			end
			phase++;
		end

		drain_block();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
